// File: hw/rtl/ecg_srp_pkg.sv
package ecg_srp_pkg;

    // Record format codes.
    localparam logic [1:0] C_FMT_3CH = 2'd0;
    localparam logic [1:0] C_FMT_4CH = 2'd1;
    localparam logic [1:0] C_FMT_9CH = 2'd2;
    localparam logic [1:0] C_FMT_NONE = 2'd3;

    // Auxiliary slot code that selects a rail voltage.
    localparam logic [1:0] C_SLOT_RAIL = 2'd3;

    localparam int C_LANES = 9;
    localparam int C_REC_BYTES = 16;

    // Sample scaling: (x >>> 4) * 1653 / 1206, saturated to 12 bits.
    localparam logic signed [30:0] C_SCALE_MUL = 31'sd1653;
    // Products at or beyond these bounds saturate the quotient.
    localparam logic signed [30:0] C_PROD_HI = 31'sd2469888;
    localparam logic signed [30:0] C_PROD_LO = -31'sd2471094;
    // Exact reciprocal of 1206 for magnitudes below 2^22.
    localparam logic [22:0] C_DIV_RECIP = 23'd7122666;
    localparam int C_DIV_SHIFT = 33;
    localparam logic [11:0] C_ELEM_MAX = 12'h7FF;
    localparam logic [11:0] C_ELEM_MIN = 12'h800;

    // Exact reciprocal of 20 for 16-bit rail values.
    localparam logic [16:0] C_RAIL_RECIP = 17'd104858;
    localparam int C_RAIL_SHIFT = 21;

    typedef struct packed {
        logic signed [23:0] sample_0;
        logic signed [23:0] sample_1;
        logic signed [23:0] sample_2;
        logic signed [23:0] sample_3;
        logic signed [23:0] sample_4;
        logic signed [23:0] sample_5;
        logic signed [23:0] sample_6;
        logic signed [23:0] sample_7;
        logic signed [23:0] sample_8;
        logic               pd_ready;
        logic [23:0]        accel_bytes;
        logic [63:0]        rail_voltages;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    // Pipeline advance strobes shared by all lanes.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_lane_adv;

    // Packed record: byte 0 leaves first.
    typedef struct packed {
        logic [C_REC_BYTES-1:0][7:0] bytes;
        logic [3:0]                  last_idx;
    } t_record;

endpackage

// File: hw/rtl/ecg_srp_lane.sv
module ecg_srp_lane (
    input  logic                  i_clk,
    input  ecg_srp_pkg::t_lane_adv i_adv,
    input  logic signed [23:0]    i_sample,
    output logic [11:0]           o_elem
);

    logic signed [30:0] w_shift_ext;
    logic signed [30:0] w_prod;
    logic signed [30:0] r_prod;
    logic signed [30:0] w_mag;
    logic [44:0]        w_qprod;
    logic [11:0]        r_quot;
    logic               r_neg;
    logic               r_hi;
    logic               r_lo;
    logic [11:0]        r_elem;
    logic [11:0]        n_elem;

    // Stage 1: arithmetic shift by 4 and multiply by the scale constant.
    assign w_shift_ext = {{11{i_sample[23]}}, i_sample[23:4]};
    assign w_prod = w_shift_ext * ecg_srp_pkg::C_SCALE_MUL;

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_prod <= w_prod;
        end
    end

    // Stage 2: saturation detect, magnitude and reciprocal multiply.
    assign w_mag = r_prod[30] ? -r_prod : r_prod;
    assign w_qprod = {23'd0, w_mag[21:0]} * {22'd0, ecg_srp_pkg::C_DIV_RECIP};

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_quot <= w_qprod[ecg_srp_pkg::C_DIV_SHIFT +: 12];
            r_neg  <= r_prod[30];
            r_hi   <= (r_prod >= ecg_srp_pkg::C_PROD_HI);
            r_lo   <= (r_prod <= ecg_srp_pkg::C_PROD_LO);
        end
    end

    // Stage 3: restore the sign and apply the 12-bit limits.
    always_comb begin
        if (r_hi) begin
            n_elem = ecg_srp_pkg::C_ELEM_MAX;
        end else if (r_lo) begin
            n_elem = ecg_srp_pkg::C_ELEM_MIN;
        end else if (r_neg) begin
            n_elem = -r_quot;
        end else begin
            n_elem = r_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_elem <= n_elem;
        end
    end

    assign o_elem = r_elem;

endmodule

// File: hw/rtl/ecg_srp_merge.sv
module ecg_srp_merge (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic [8:0][11:0]     i_elem,
    input  logic [1:0]           i_fmt,
    input  logic [3:0]           i_flags,
    input  logic [7:0]           i_aux,
    output ecg_srp_pkg::t_record o_rec
);

    ecg_srp_pkg::t_record r_rec;
    ecg_srp_pkg::t_record n_rec;

    // Lay out the lane results, aux byte and flags for the selected format.
    always_comb begin
        n_rec = '0;
        case (i_fmt)
            ecg_srp_pkg::C_FMT_3CH: begin
                n_rec.bytes[0] = i_elem[0][11:4];
                n_rec.bytes[1] = {i_elem[0][3:0], i_elem[1][11:8]};
                n_rec.bytes[2] = i_elem[1][7:0];
                n_rec.bytes[3] = i_elem[2][11:4];
                n_rec.bytes[4] = {i_elem[2][3:0], i_flags};
                n_rec.bytes[5] = i_aux;
                n_rec.last_idx = 4'd5;
            end
            ecg_srp_pkg::C_FMT_4CH: begin
                n_rec.bytes[0] = i_elem[0][11:4];
                n_rec.bytes[1] = {i_elem[0][3:0], i_elem[1][11:8]};
                n_rec.bytes[2] = i_elem[1][7:0];
                n_rec.bytes[3] = i_elem[2][11:4];
                n_rec.bytes[4] = {i_elem[2][3:0], i_elem[8][11:8]};
                n_rec.bytes[5] = i_elem[8][7:0];
                n_rec.bytes[6] = i_aux;
                n_rec.bytes[7] = {4'd0, i_flags};
                n_rec.last_idx = 4'd7;
            end
            ecg_srp_pkg::C_FMT_9CH: begin
                for (int p = 0; p < 4; p++) begin
                    n_rec.bytes[3*p]     = i_elem[2*p][11:4];
                    n_rec.bytes[3*p + 1] = {i_elem[2*p][3:0], i_elem[2*p + 1][11:8]};
                    n_rec.bytes[3*p + 2] = i_elem[2*p + 1][7:0];
                end
                n_rec.bytes[12] = i_elem[8][11:4];
                n_rec.bytes[13] = {i_elem[8][3:0], 4'd0};
                n_rec.bytes[14] = i_aux;
                n_rec.bytes[15] = {4'd0, i_flags};
                n_rec.last_idx  = 4'd15;
            end
            default: begin
                n_rec = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= n_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

// File: hw/rtl/ecg_srp_serial.sv
module ecg_srp_serial (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rec_valid,
    input  ecg_srp_pkg::t_record   i_rec,
    output logic                   o_rec_take,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ecg_srp_pkg::t_out_item o_out_data
);

    ecg_srp_pkg::t_record r_rec;
    logic [3:0]           r_idx;
    logic                 r_busy;
    logic                 w_out_acc;
    logic                 w_at_last;

    assign w_out_acc = r_busy && !i_out_stall;
    assign w_at_last = (r_idx == r_rec.last_idx);

    // A new record loads when idle or as the final byte of the current one leaves.
    assign o_rec_take = i_rec_valid && (!r_busy || (w_out_acc && w_at_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_rec_take) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_out_acc) begin
            if (w_at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // Record payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_rec_take) begin
            r_rec <= i_rec;
        end
    end

    assign o_out_valid          = r_busy;
    assign o_out_data.out_byte  = r_rec.bytes[r_idx];
    assign o_out_data.last_byte = w_at_last;

endmodule

// File: hw/rtl/ecg_sample_record_packer_core.sv
// ECG sample record packer.
// Input channel: i_in_valid / o_in_stall with one frame per item (nine raw
// 24-bit samples, the pace-detect bit, accelerometer bytes and rail voltages).
// Output channel: o_out_valid / i_out_stall with one record byte per item;
// last_byte marks the final byte of a record.
// Configuration: i_cfg_valid / o_cfg_ready writes record_format (6, 8 or 16
// bytes per record); o_cfg_ready is always high. Format 3 drops frames.
// Path: a frame passes nine parallel scaling lanes (three stages), a merge
// register and the serializer record register before its first byte shows.
// Throughput: the serializer sends one byte per cycle while the receiver does
// not stall. Four frames can be in flight ahead of the serializer, so frames
// are taken in consecutive cycles until that fills.
// Reset (synchronous, active low) empties the pipeline, sets format 2 and
// starts the aux rotation at accelerometer X and the battery rail.
// When the receiver stalls, the current byte holds; the pipeline fills and
// then o_in_stall rises until bytes drain.
module ecg_sample_record_packer_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ecg_srp_pkg::t_in_item  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ecg_srp_pkg::t_out_item o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_data
);

    logic [1:0] r_fmt;
    logic [1:0] r_aux_slot;
    logic [1:0] r_rail_idx;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic w_take;
    logic w_in_acc;
    logic w_enter;

    ecg_srp_pkg::t_lane_adv w_adv;
    logic signed [8:0][23:0] w_samples;
    logic [8:0][11:0]        w_elem;
    ecg_srp_pkg::t_record    w_rec;

    logic [2:0]  w_code;
    logic [3:0]  w_flags;
    logic [1:0]  r_s1_fmt, r_s2_fmt, r_s3_fmt;
    logic [3:0]  r_s1_flags, r_s2_flags, r_s3_flags;
    logic        r_s1_is_rail;
    logic [15:0] r_s1_rail;
    logic [7:0]  r_s1_accel;
    logic [7:0]  r_s2_aux, r_s3_aux;
    logic [32:0] w_rail_prod;

    // Configuration register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= ecg_srp_pkg::C_FMT_9CH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fmt <= i_cfg_data;
        end
    end

    // Elastic pipeline: a stage loads when it is empty or its contents move on.
    assign w_rdy4 = !r_v4 || w_take;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1;

    assign w_in_acc = i_in_valid && w_rdy1;
    assign w_enter  = w_in_acc && (r_fmt != ecg_srp_pkg::C_FMT_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= w_enter;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // Aux slot rotation advances once per frame that produces a record.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aux_slot <= '0;
            r_rail_idx <= '0;
        end else if (w_enter) begin
            if (r_aux_slot == ecg_srp_pkg::C_SLOT_RAIL) begin
                r_aux_slot <= '0;
                r_rail_idx <= r_rail_idx + 2'd1;
            end else begin
                r_aux_slot <= r_aux_slot + 2'd1;
            end
        end
    end

    assign w_code  = (r_aux_slot == ecg_srp_pkg::C_SLOT_RAIL) ?
                     (3'd3 + {1'b0, r_rail_idx}) : {1'b0, r_aux_slot};
    assign w_flags = {w_code, i_in_data.pd_ready};

    // Side path stage 1: pick the aux source and form the flag nibble.
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_fmt     <= r_fmt;
            r_s1_flags   <= w_flags;
            r_s1_is_rail <= (r_aux_slot == ecg_srp_pkg::C_SLOT_RAIL);
            r_s1_rail    <= i_in_data.rail_voltages[16*r_rail_idx +: 16];
            r_s1_accel   <= i_in_data.accel_bytes[8*r_aux_slot +: 8];
        end
    end

    // Side path stage 2: rail value divided by 20 through its reciprocal.
    assign w_rail_prod = {17'd0, r_s1_rail} * {16'd0, ecg_srp_pkg::C_RAIL_RECIP};

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_fmt   <= r_s1_fmt;
            r_s2_flags <= r_s1_flags;
            r_s2_aux   <= r_s1_is_rail ? w_rail_prod[ecg_srp_pkg::C_RAIL_SHIFT +: 8]
                                       : r_s1_accel;
        end
    end

    // Side path stage 3: keep in step with the lane outputs.
    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_fmt   <= r_s2_fmt;
            r_s3_flags <= r_s2_flags;
            r_s3_aux   <= r_s2_aux;
        end
    end

    // Nine scaling lanes, one per channel.
    assign w_adv.s1 = w_rdy1;
    assign w_adv.s2 = w_rdy2;
    assign w_adv.s3 = w_rdy3;

    assign w_samples[0] = i_in_data.sample_0;
    assign w_samples[1] = i_in_data.sample_1;
    assign w_samples[2] = i_in_data.sample_2;
    assign w_samples[3] = i_in_data.sample_3;
    assign w_samples[4] = i_in_data.sample_4;
    assign w_samples[5] = i_in_data.sample_5;
    assign w_samples[6] = i_in_data.sample_6;
    assign w_samples[7] = i_in_data.sample_7;
    assign w_samples[8] = i_in_data.sample_8;

    for (genvar g = 0; g < ecg_srp_pkg::C_LANES; g++) begin : g_lane
        ecg_srp_lane u_lane (
            .i_clk    (i_clk),
            .i_adv    (w_adv),
            .i_sample (w_samples[g]),
            .o_elem   (w_elem[g])
        );
    end

    // Merge the lane results into one record.
    ecg_srp_merge u_merge (
        .i_clk   (i_clk),
        .i_load  (w_rdy4),
        .i_elem  (w_elem),
        .i_fmt   (r_s3_fmt),
        .i_flags (r_s3_flags),
        .i_aux   (r_s3_aux),
        .o_rec   (w_rec)
    );

    // Byte serializer on the output channel.
    ecg_srp_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (r_v4),
        .i_rec       (w_rec),
        .o_rec_take  (w_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hw/rtl/ecg_srp_checker.sv
module ecg_srp_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input ecg_srp_pkg::t_out_item o_out_data
);

    // A stalled output item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output item changed while stalled");

    // A record's bytes follow one another without gaps.
    a_rec_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last_byte) |=> o_out_valid)
        else $error("gap inside a record");

    // Reset leaves no output pending.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // The empty pipeline takes an item right after reset.
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

endmodule

bind ecg_sample_record_packer_core ecg_srp_checker u_ecg_srp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: tb/ecg_srp_record_checker.sv
`timescale 1ns / 100ps

module ecg_srp_record_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  ecg_srp_pkg::t_in_item  i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  ecg_srp_pkg::t_out_item i_out_data,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [1:0]             i_cfg_data,
    output int                     o_bytes_due,
    output int                     o_fail_count
);

    // Shadow copy of the format register and of the aux rotation.
    logic [1:0]              record_format;
    logic [1:0]              aux_slot;
    logic [1:0]              rail_index;
    ecg_srp_pkg::t_out_item  record_bytes_due [$];
    int                      mismatches = 0;

    // Shift right by 4 with floor, scale by 1653/1206 toward zero, then clamp to 12 bits.
    function automatic logic [11:0] scale_to_12b(input logic signed [23:0] raw);
        longint v;
        longint q;
        v = raw;
        v = v >>> 4;
        q = (v * 1653) / 1206;
        if (q > 2047) begin
            q = 2047;
        end else if (q < -2048) begin
            q = -2048;
        end
        return q[11:0];
    endfunction

    // Builds the byte record for one frame and advances the aux rotation.
    function automatic void predict_record(input ecg_srp_pkg::t_in_item f);
        logic [11:0]            e [9];
        logic [7:0]             aux;
        logic [3:0]             code;
        logic [3:0]             flags;
        logic [15:0]            rail;
        logic [127:0]           rec;
        int                     nbytes;
        int                     i;
        ecg_srp_pkg::t_out_item b;

        if (record_format == ecg_srp_pkg::C_FMT_NONE) begin
            return;
        end

        e[0] = scale_to_12b(f.sample_0);
        e[1] = scale_to_12b(f.sample_1);
        e[2] = scale_to_12b(f.sample_2);
        e[3] = scale_to_12b(f.sample_3);
        e[4] = scale_to_12b(f.sample_4);
        e[5] = scale_to_12b(f.sample_5);
        e[6] = scale_to_12b(f.sample_6);
        e[7] = scale_to_12b(f.sample_7);
        e[8] = scale_to_12b(f.sample_8);

        // The rail slot reports one rail divided by 20; the others pass an accelerometer byte.
        if (aux_slot == ecg_srp_pkg::C_SLOT_RAIL) begin
            rail = f.rail_voltages[16 * rail_index +: 16];
            aux = 8'(rail / 16'd20);
            code = 4'd3 + 4'(rail_index);
            rail_index = rail_index + 2'd1;
            aux_slot = 2'd0;
        end else begin
            aux = f.accel_bytes[8 * aux_slot +: 8];
            code = 4'(aux_slot);
            aux_slot = aux_slot + 2'd1;
        end
        flags = {code[2:0], f.pd_ready};

        // Two 12-bit values in three bytes is a plain concatenation; byte 0 sits at the top.
        case (record_format)
            ecg_srp_pkg::C_FMT_3CH: begin
                rec = {e[0], e[1], e[2], flags, aux, 80'h0};
                nbytes = 6;
            end
            ecg_srp_pkg::C_FMT_4CH: begin
                rec = {e[0], e[1], e[2], e[8], aux, 4'h0, flags, 64'h0};
                nbytes = 8;
            end
            default: begin
                rec = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8],
                       4'h0, aux, 4'h0, flags};
                nbytes = 16;
            end
        endcase

        for (i = 0; i < nbytes; i++) begin
            b.out_byte = rec[127 - 8 * i -: 8];
            b.last_byte = (i == nbytes - 1);
            record_bytes_due.push_back(b);
        end
    endfunction

    // Predict on each accepted frame, compare each accepted byte, track format writes.
    always @(posedge i_clk) begin : record_check
        ecg_srp_pkg::t_out_item want;
        if (!i_rst_n) begin
            record_format = ecg_srp_pkg::C_FMT_9CH;
            aux_slot = 2'd0;
            rail_index = 2'd0;
            record_bytes_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_record(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (record_bytes_due.size() == 0) begin
                    $display("%0t: byte with nothing expected, got byte %h last %b",
                             $time, i_out_data.out_byte, i_out_data.last_byte);
                    mismatches++;
                end else begin
                    want = record_bytes_due.pop_front();
                    if (want.out_byte !== i_out_data.out_byte) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.out_byte, i_out_data.out_byte);
                        mismatches++;
                    end
                    if (want.last_byte !== i_out_data.last_byte) begin
                        $display("%0t: last_byte expected %b actual %b",
                                 $time, want.last_byte, i_out_data.last_byte);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                record_format = i_cfg_data;
            end
        end
        o_bytes_due <= record_bytes_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: tb/tb_ecg_sample_record_packer_core.sv
`timescale 1ns / 100ps

module tb_ecg_sample_record_packer_core;

    localparam int C_RANDOM_FRAMES = 40;
    localparam int C_DROP_FRAMES = 10;
    localparam int C_PHASES = 10;
    localparam int C_SETTLE_CYCLES = 12;
    localparam int C_CYCLE_LIMIT = 200000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    ecg_srp_pkg::t_in_item  in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    ecg_srp_pkg::t_out_item out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_data = 2'd0;

    logic       tx_idle_on = 1'b1;
    logic       rx_idle_on = 1'b1;
    int         bytes_due;
    int         fail_count;
    int         cycle_count = 0;
    logic [1:0] phase_fmt [C_PHASES];

    always #2 clk = ~clk;

    ecg_sample_record_packer_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    ecg_srp_record_checker i_record_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_bytes_due  (bytes_due),
        .o_fail_count (fail_count)
    );

    // The byte receiver stalls at random while idling is enabled.
    always @(posedge clk) begin
        out_stall <= rx_idle_on && ($urandom_range(0, 99) < 31);
    end

    // Guard against a hung block.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= C_CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Mostly uniform codes, with a share near the clamp points, near zero and at the ends.
    function automatic logic signed [23:0] random_sample();
        logic [23:0] mag;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 24'($urandom);
            5, 6: mag = 24'd23880 + 24'($urandom_range(0, 63));
            7: mag = 24'($urandom_range(0, 64));
            8: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: mag = 24'($urandom_range(0, 1));
        endcase
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    function automatic ecg_srp_pkg::t_in_item random_frame();
        ecg_srp_pkg::t_in_item f;
        int                    lane;
        f.sample_0 = random_sample();
        f.sample_1 = random_sample();
        f.sample_2 = random_sample();
        f.sample_3 = random_sample();
        f.sample_4 = random_sample();
        f.sample_5 = random_sample();
        f.sample_6 = random_sample();
        f.sample_7 = random_sample();
        f.sample_8 = random_sample();
        f.pd_ready = 1'($urandom_range(0, 1));
        f.accel_bytes = 24'($urandom);
        f.rail_voltages = {$urandom, $urandom};
        // Sometimes put a rail near the point where the divided value wraps.
        if ($urandom_range(0, 3) == 0) begin
            lane = $urandom_range(0, 3);
            f.rail_voltages[16 * lane +: 16] = 16'd5100 + 16'($urandom_range(0, 40));
        end
        return f;
    endfunction

    // Corner codes rotated across the channels, with rail values at the wrap and clamp points.
    function automatic ecg_srp_pkg::t_in_item directed_frame(input int k);
        logic signed [23:0]    corner [12];
        ecg_srp_pkg::t_in_item f;
        corner = '{24'sh7FFFFF, 24'sh800000, 24'sd0, -24'sd1, 24'sd23904, 24'sd23920,
                   -24'sd23904, -24'sd23920, -24'sd17, 24'sd15, 24'sd16, -24'sd16};
        f.sample_0 = corner[k % 12];
        f.sample_1 = corner[(k + 1) % 12];
        f.sample_2 = corner[(k + 2) % 12];
        f.sample_3 = corner[(k + 3) % 12];
        f.sample_4 = corner[(k + 4) % 12];
        f.sample_5 = corner[(k + 5) % 12];
        f.sample_6 = corner[(k + 6) % 12];
        f.sample_7 = corner[(k + 7) % 12];
        f.sample_8 = corner[(k + 8) % 12];
        f.pd_ready = k[0];
        f.accel_bytes = k[1] ? 24'h00FF5A : 24'hFF00A5;
        case (k / 4)
            0: f.rail_voltages = {4{16'hFFFF}};
            1: f.rail_voltages = 64'h0;
            2: f.rail_voltages = {16'd19, 16'd20, 16'd5119, 16'd5120};
            default: f.rail_voltages = {16'd5120, 16'd5119, 16'd20, 16'd19};
        endcase
        return f;
    endfunction

    // Offer one frame, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_frame(input ecg_srp_pkg::t_in_item f);
        while (tx_idle_on && $urandom_range(0, 99) < 31) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= f;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted byte has arrived.
    task automatic wait_records_out();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (bytes_due != 0);
    endtask

    // Format writes happen only with the block idle; dropped frames never enter the pipeline.
    task automatic write_format(input logic [1:0] fmt);
        wait_records_out();
        repeat (C_SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= fmt;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int k;
        int p;
        int n;
        int frames;

        phase_fmt = '{ecg_srp_pkg::C_FMT_3CH, ecg_srp_pkg::C_FMT_4CH,
                      ecg_srp_pkg::C_FMT_NONE, ecg_srp_pkg::C_FMT_9CH,
                      ecg_srp_pkg::C_FMT_4CH, ecg_srp_pkg::C_FMT_3CH,
                      ecg_srp_pkg::C_FMT_9CH, ecg_srp_pkg::C_FMT_NONE,
                      ecg_srp_pkg::C_FMT_4CH, ecg_srp_pkg::C_FMT_9CH};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner frames in the reset format walk the aux byte through all four rails.
        for (k = 0; k < 16; k++) begin
            send_frame(directed_frame(k));
        end
        write_format(ecg_srp_pkg::C_FMT_3CH);
        for (k = 0; k < 4; k++) begin
            send_frame(directed_frame(k + 4));
        end
        write_format(ecg_srp_pkg::C_FMT_4CH);
        for (k = 0; k < 4; k++) begin
            send_frame(directed_frame(k + 8));
        end

        // Random phases over every format; one phase runs with no idling on either side.
        for (p = 0; p < C_PHASES; p++) begin
            write_format(phase_fmt[p]);
            tx_idle_on = (p != 3);
            rx_idle_on <= (p != 3);
            frames = (phase_fmt[p] == ecg_srp_pkg::C_FMT_NONE) ?
                     C_DROP_FRAMES : C_RANDOM_FRAMES;
            for (n = 0; n < frames; n++) begin
                if (p == 1 && n == C_RANDOM_FRAMES / 2) begin
                    wait_records_out();
                end
                send_frame(random_frame());
            end
        end

        wait_records_out();
        repeat (C_SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
